// ===== rtl/core/ars_pkg.sv =====
// ----------------------------------------------------------------------------
// ars_pkg: shared types and constants of the altitude reference selector
// Holds the input and result word layouts and the phase codes.
// ----------------------------------------------------------------------------
package ars_pkg;

  // phase codes of the reference state machine
  localparam logic [1:0] PhWait    = 2'd0;
  localparam logic [1:0] PhGround  = 2'd1;
  localparam logic [1:0] PhTakeoff = 2'd2;

  // width of the saturated reference height, 25 bits
  localparam int RefW = 25;

  // one input word per tick
  typedef struct packed {
    logic signed [23:0] baro_abs;
    logic [15:0]        range_height;
    logic [15:0]        flow_height;
    logic               in_flight;
    logic               imu_ready;
    logic               airborne;
    logic               auto_takeoff;
    logic               flow_ok;
    logic               range_on;
    logic               flow_range_on;
  } in_word_t;

  // one result word per tick
  typedef struct packed {
    logic signed [RefW-1:0] ref_height;
    logic                   fusion_pause;
  } out_word_t;

endpackage

// ===== rtl/core/ars_if.sv =====
// ----------------------------------------------------------------------------
// ars_in_if / ars_out_if: valid/ready channels of the selector
// One channel carries input words, the other carries result words.
// ----------------------------------------------------------------------------
interface ars_in_if;
  logic             valid;
  logic             ready;
  ars_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ars_out_if;
  logic               valid;
  logic               ready;
  ars_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ars_core.sv =====
// ----------------------------------------------------------------------------
// ars_core: per-tick reference height update
// Holds the phase machine and offset state, computes one result per step.
// ----------------------------------------------------------------------------
module ars_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  ars_pkg::in_word_t  word_i,
  input  logic signed [15:0] baro_corr_i,
  output ars_pkg::out_word_t res_o
);

  // state registers
  logic [1:0]         phase_q, phase_d;
  logic               latched_q, latched_d;
  logic signed [23:0] ground_q, ground_d;
  logic signed [31:0] rel_q, rel_d;
  logic signed [31:0] btr_q, btr_d;
  logic signed [31:0] rtb_q, rtb_d;
  logic signed [17:0] fix_q, fix_d;

  logic [1:0]         phase_a;
  logic signed [31:0] rtb_eff;
  logic signed [31:0] baro32;
  logic signed [31:0] h32;
  logic signed [31:0] btr_use;
  logic signed [31:0] rng;
  logic signed [33:0] sum34;
  logic signed [33:0] half34;
  logic signed [31:0] used;
  logic               pause;
  logic               use_range;
  logic [15:0]        h;

  // per-tick update
  always_comb begin
    baro32    = {{8{word_i.baro_abs[23]}}, word_i.baro_abs};
    phase_d   = phase_q;
    latched_d = latched_q;
    ground_d  = ground_q;
    rel_d     = rel_q;
    btr_d     = btr_q;

    // take-off tracking
    if (word_i.in_flight) begin
      phase_a = ars_pkg::PhTakeoff;
      rtb_eff = rtb_q;
    end else begin
      phase_a = (phase_q == ars_pkg::PhTakeoff) ? ars_pkg::PhWait : phase_q;
      rtb_eff = '0;
    end
    rtb_d = rtb_eff;

    // relative baro height or ground latch
    if (phase_a != ars_pkg::PhWait) begin
      rel_d   = baro32 - {{8{ground_q[23]}}, ground_q}
                + {{14{fix_q[17]}}, fix_q} + rtb_eff;
      phase_d = phase_a;
    end else begin
      ground_d = word_i.baro_abs;
      phase_d  = word_i.imu_ready ? ars_pkg::PhGround : phase_a;
    end

    // fix term for the next tick
    pause = !word_i.airborne && word_i.auto_takeoff;
    fix_d = pause ? '0 : -({{2{baro_corr_i[15]}}, baro_corr_i} <<< 1);

    // range source selection, jump-free offset and halving average
    h         = word_i.flow_range_on ? word_i.flow_height : word_i.range_height;
    h32       = {16'd0, h};
    btr_use   = latched_q ? btr_q : rel_d - h32;
    rng       = h32 + btr_use;
    sum34     = {{2{rtb_eff[31]}}, rtb_eff} + {{2{rng[31]}}, rng}
                - {{2{rel_d[31]}}, rel_d};
    half34    = (sum34 + {33'd0, sum34[33]}) >>> 1;
    use_range = 1'b0;
    if (word_i.flow_ok && (phase_d != ars_pkg::PhWait)) begin
      if (word_i.range_on || word_i.flow_range_on) begin
        use_range = 1'b1;
        btr_d     = btr_use;
        latched_d = 1'b1;
        rtb_d     = half34[31:0];
      end else begin
        latched_d = 1'b0;
      end
    end
    used = use_range ? rng : rel_d;

    // saturate to the 25 bit result
    if (used[31:ars_pkg::RefW-1] == '0 || used[31:ars_pkg::RefW-1] == '1) begin
      res_o.ref_height = used[ars_pkg::RefW-1:0];
    end else if (used[31]) begin
      res_o.ref_height = {1'b1, {(ars_pkg::RefW-1){1'b0}}};
    end else begin
      res_o.ref_height = {1'b0, {(ars_pkg::RefW-1){1'b1}}};
    end
    res_o.fusion_pause = pause;
  end

  // state update on each step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ars_pkg::PhWait;
      latched_q <= 1'b0;
      ground_q  <= '0;
      rel_q     <= '0;
      btr_q     <= '0;
      rtb_q     <= '0;
      fix_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      latched_q <= latched_d;
      ground_q  <= ground_d;
      rel_q     <= rel_d;
      btr_q     <= btr_d;
      rtb_q     <= rtb_d;
      fix_q     <= fix_d;
    end
  end

endmodule

// ===== rtl/core/altitude_reference_selector.sv =====
// Path: an accepted input word is held in the input register, its result in
// the result register on out_o. Throughput: one word per cycle while out_o
// is ready; the state update is a single pass through ars_core in between.
// Reset: rst_ni clears the phase machine, all offsets, the fix term, the
// baro_correction register and both valid flags.
// ----------------------------------------------------------------------------
// altitude_reference_selector: height reference for vertical fusion
// Input register, per-tick update core and result register with handshake.
// ----------------------------------------------------------------------------
module altitude_reference_selector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  ars_in_if.sink      in_i,
  ars_out_if.source   out_o
);

  logic                signed [15:0] corr_q;
  logic                s1_valid_q;
  ars_pkg::in_word_t   s1_word_q;
  logic                out_valid_q;
  ars_pkg::out_word_t  out_word_q;
  ars_pkg::out_word_t  res;
  logic                adv;

  // result register frees up when empty or taken
  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q <= '0;
    end else if (cfg_we_i) begin
      corr_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_word_q <= in_i.data;
    end
  end

  // per-tick update
  ars_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .word_i      (s1_word_q),
    .baro_corr_i (corr_q),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for altitude_reference_selector
// Drives input words through the valid/ready channel and predicts every
// result word from its own copy of the phase machine and the height offsets.
// A directed pass covers saturation, latching and phase changes. Random
// flight sequences follow, under several baro_correction settings and
// idling patterns.
// ----------------------------------------------------------------------------
module testbench;

  // predicts reference heights and holds the ones still to come
  class ref_height_predictor;
    logic signed [15:0] baro_fix_cfg;
    logic [1:0]         phase;
    bit                 range_locked;
    logic signed [31:0] ground_zero;
    logic signed [31:0] baro_rel;
    logic signed [31:0] baro_to_rng;
    logic signed [31:0] rng_to_baro;
    logic signed [31:0] fix_term;
    ars_pkg::out_word_t expected_heights[$];
    int                 errors;

    function new();
      baro_fix_cfg = '0;
      phase        = ars_pkg::PhWait;
      range_locked = 1'b0;
      ground_zero  = '0;
      baro_rel     = '0;
      baro_to_rng  = '0;
      rng_to_baro  = '0;
      fix_term     = '0;
      errors       = 0;
    endfunction

    function int pending();
      return expected_heights.size();
    endfunction

    // one tick of the selector for an accepted input word
    function void note_input(ars_pkg::in_word_t w);
      longint             baro;
      longint             h;
      longint             used;
      longint             sum;
      logic signed [31:0] rng32;
      ars_pkg::out_word_t e;
      baro = longint'($signed(w.baro_abs));
      // phase machine: take-off entry and landing
      if (w.in_flight) begin
        phase = ars_pkg::PhTakeoff;
      end else begin
        if (phase == ars_pkg::PhTakeoff) phase = ars_pkg::PhWait;
        rng_to_baro = '0;
      end
      // relative height, or follow the ground while waiting
      if (phase != ars_pkg::PhWait) begin
        baro_rel = 32'(baro - ground_zero + fix_term + rng_to_baro);
      end else begin
        ground_zero = 32'(baro);
        if (w.imu_ready) phase = ars_pkg::PhGround;
      end
      // pause before automatic take-off; fix term for the next tick
      e.fusion_pause = !w.airborne && w.auto_takeoff;
      fix_term = e.fusion_pause ? 32'sd0 : -32'sd2 * baro_fix_cfg;
      used = longint'(baro_rel);
      // range height with a jump-free offset
      if (w.flow_ok && phase != ars_pkg::PhWait) begin
        if (w.range_on || w.flow_range_on) begin
          h = w.flow_range_on ? longint'(w.flow_height) : longint'(w.range_height);
          if (!range_locked) begin
            baro_to_rng  = 32'(baro_rel - h);
            range_locked = 1'b1;
          end
          rng32 = 32'(h + baro_to_rng);
          used  = longint'(rng32);
          sum   = rng_to_baro + (used - baro_rel);
          rng_to_baro = 32'(sum / 2);
        end else begin
          range_locked = 1'b0;
        end
      end
      // saturate to 25 bits
      if (used > 64'sd16777215) used = 64'sd16777215;
      if (used < -64'sd16777216) used = -64'sd16777216;
      e.ref_height = used[ars_pkg::RefW-1:0];
      expected_heights.push_back(e);
    endfunction

    // compare a result word with the oldest prediction
    function void check_result(ars_pkg::out_word_t r);
      ars_pkg::out_word_t e;
      if (expected_heights.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, ref_height %0d fusion_pause %0b",
                 $time, $signed(r.ref_height), r.fusion_pause);
        return;
      end
      e = expected_heights.pop_front();
      if (r.ref_height !== e.ref_height) begin
        errors++;
        $display("%0t: ref_height expected %0d actual %0d",
                 $time, $signed(e.ref_height), $signed(r.ref_height));
      end
      if (r.fusion_pause !== e.fusion_pause) begin
        errors++;
        $display("%0t: fusion_pause expected %0b actual %0b",
                 $time, e.fusion_pause, r.fusion_pause);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  ars_in_if  in_if ();
  ars_out_if out_if ();

  int tx_idle_pct;
  int rx_idle_pct;
  int words_sent;

  ref_height_predictor heights;

  altitude_reference_selector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  // watch both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) heights.note_input(in_if.data);
    if (rst_ni && out_if.valid && out_if.ready) heights.check_result(out_if.data);
  end

  // build an input word from its fields
  function automatic ars_pkg::in_word_t mk(logic signed [23:0] baro, logic [15:0] rng,
                                           logic [15:0] flw, bit to, bit imu, bit air,
                                           bit auto_to, bit fok, bit ron, bit fron);
    ars_pkg::in_word_t w;
    w.baro_abs      = baro;
    w.range_height  = rng;
    w.flow_height   = flw;
    w.in_flight     = to;
    w.imu_ready     = imu;
    w.airborne      = air;
    w.auto_takeoff  = auto_to;
    w.flow_ok       = fok;
    w.range_on      = ron;
    w.flow_range_on = fron;
    return w;
  endfunction

  function automatic ars_pkg::in_word_t noise_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(ars_pkg::in_word_t)-1:0];
  endfunction

  // offer one word, with random idle cycles ahead of it
  task automatic send_word(ars_pkg::in_word_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // stop sending until every result word is back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (heights.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_baro_fix(logic signed [15:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    heights.baro_fix_cfg = v;
  endtask

  // wait on the ground, latch it, fly with range tracking, then land
  task automatic fly_sequence();
    ars_pkg::in_word_t w;
    int                gnd;
    int                bh;
    int                rh;
    int                fh;
    gnd = ($urandom_range(0, 7) == 0) ? int'($urandom)
                                      : int'($urandom_range(0, 400000)) - 200000;
    rh = $urandom_range(0, 65535);
    fh = $urandom_range(0, 65535);
    repeat ($urandom_range(0, 2)) begin
      w = noise_word();
      w.in_flight = 1'b0;
      w.imu_ready = 1'b0;
      w.baro_abs  = gnd[23:0];
      send_word(w);
    end
    w = noise_word();
    w.in_flight = 1'b0;
    w.imu_ready = 1'b1;
    w.baro_abs  = gnd[23:0];
    send_word(w);
    repeat ($urandom_range(4, 30)) begin
      w = noise_word();
      w.in_flight    = 1'b1;
      bh = gnd + int'($urandom_range(0, 4000)) - 2000;
      w.baro_abs     = bh[23:0];
      rh = rh + int'($urandom_range(0, 200)) - 100;
      fh = fh + int'($urandom_range(0, 200)) - 100;
      w.range_height = rh[15:0];
      w.flow_height  = fh[15:0];
      w.flow_ok      = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 6) == 0) begin
        w.range_on      = 1'b0;
        w.flow_range_on = 1'b0;
      end else if (!w.range_on && !w.flow_range_on) begin
        w.range_on = 1'b1;
      end
      w.airborne = ($urandom_range(0, 5) != 0);
      send_word(w);
    end
    repeat ($urandom_range(1, 2)) begin
      w = noise_word();
      w.in_flight = 1'b0;
      send_word(w);
    end
  endtask

  task automatic random_phase(int tx, int rx, int quota);
    int target;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    target = words_sent + quota;
    while (words_sent < target) begin
      if ($urandom_range(0, 4) != 0) begin
        fly_sequence();
      end else begin
        repeat ($urandom_range(1, 5)) send_word(noise_word());
      end
    end
  endtask

  // main sequence
  initial begin
    heights = new();
    words_sent   = 0;
    tx_idle_pct  = 8;
    rx_idle_pct  = 51;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: most negative correction gives the largest positive fix
    write_baro_fix(-16'sd32768);
    // ground latched at the lowest height, range tracking starts in the same word
    send_word(mk(-24'sd8388608, 16'd0, 16'd0, 0, 1, 1, 0, 1, 1, 0));
    // top saturation
    send_word(mk(24'sd8388607, 16'd0, 16'd0, 0, 0, 1, 0, 0, 0, 0));
    // range still on, the offset latched with the ground word is kept
    send_word(mk(24'sd8388607, 16'hffff, 16'd0, 0, 0, 1, 0, 1, 1, 0));
    send_word(mk(24'sd8388000, 16'd100, 16'd0, 1, 0, 1, 0, 1, 0, 1));
    send_word(mk(24'sd8388000, 16'd100, 16'hffff, 1, 0, 1, 0, 1, 0, 1));
    // range off clears the latch, next switch-on relatches
    send_word(mk(24'sd100, 16'd7, 16'd3, 1, 0, 1, 0, 1, 0, 0));
    send_word(mk(-24'sd5, 16'd7, 16'd3, 1, 0, 1, 0, 1, 1, 0));
    // odd difference, halving toward zero
    send_word(mk(-24'sd9, 16'd2, 16'd3, 1, 0, 1, 0, 1, 1, 0));
    // pause before automatic take-off, both range sources on
    send_word(mk(-24'sd9, 16'd5, 16'd3, 1, 0, 0, 1, 1, 1, 1));
    send_word(mk(24'sd0, 16'd0, 16'd0, 1, 0, 0, 0, 1, 1, 0));
    // landing back to waiting, imu not ready
    send_word(mk(-24'sd40, 16'd0, 16'd0, 0, 0, 1, 1, 1, 1, 0));
    // ground latched at the highest height
    send_word(mk(24'sd8388607, 16'd0, 16'd0, 0, 1, 1, 0, 0, 0, 0));
    write_baro_fix(16'sd32767);
    // old fix still applied, then bottom saturation
    send_word(mk(-24'sd8388608, 16'd0, 16'd0, 0, 0, 1, 0, 0, 0, 0));
    send_word(mk(-24'sd8388608, 16'd0, 16'd0, 1, 0, 1, 0, 0, 0, 0));
    send_word(mk(-24'sd8388608, 16'hffff, 16'hffff, 1, 1, 1, 1, 1, 1, 1));
    send_word(mk(24'sd0, 16'd0, 16'd0, 0, 0, 0, 0, 0, 0, 0));

    // random: slow receiver, with one full hold-off in the middle
    write_baro_fix(16'($urandom));
    random_phase(8, 51, 100);
    wait_drained();
    random_phase(8, 51, 100);
    // random: slow sender
    write_baro_fix(-16'sd32768);
    random_phase(51, 8, 200);
    // random: no idling
    write_baro_fix(16'sd0);
    random_phase(0, 0, 100);
    write_baro_fix(16'sd32767);
    random_phase(0, 0, 100);

    // drain and finish
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (heights.errors == 0 && heights.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
